// ----- rtl/idle_timeout_xor_frame_receiver_top_defines.svh -----
// assertion macros for the idle timeout frame receiver
`ifndef IDLE_TIMEOUT_XOR_FRAME_RECEIVER_TOP_DEFINES_SVH
`define IDLE_TIMEOUT_XOR_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITXFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itxfr check failed");

// next-cycle implication, checked outside reset
`define ITXFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itxfr check failed");

`endif

// ----- rtl/itxfr_pkg.sv -----
// shared types and constants for the idle timeout frame receiver
package itxfr_pkg;

  localparam int BUFFER_BYTES_DEF = 257;
  localparam int TIMEOUT_W        = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1;
  localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;
  localparam int IDX_W            = 9;
  localparam int BYTE_W           = 8;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLAIM = 2'd3
  } req_t;

  // result of one item, minus the byte that comes back from the store
  typedef struct packed {
    logic             accepted;
    logic             rejected;
    logic             overflow;
    logic             ready;
    logic [IDX_W-1:0] length;
    logic             rd_ok;
    logic             busy;
  } itxfr_res_t;

endpackage

// ----- rtl/itxfr_ram.sv -----
// generic single-port ram with registered read
module itxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/itxfr_ctrl.sv -----
// frame state, idle counter, running xor and store access per item
module itxfr_ctrl import itxfr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic [IDX_W-1:0]     read_index,
  output logic                 mem_we,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_addr,
  output logic [BYTE_W-1:0]    mem_wdata,
  output itxfr_res_t           res
);

  logic [TIMEOUT_W-1:0] timeout;
  logic                 in_frame, in_frame_next;
  logic                 pending, pending_next;
  logic [CW-1:0]        count, count_next;
  logic [BYTE_W-1:0]    run_xor, run_xor_next;
  logic [TIMEOUT_W-1:0] idle, idle_next;

  logic [TIMEOUT_W-1:0] idle_inc;
  logic [AW+IDX_W-1:0]  idx_ext;
  logic [CW-1:0]        count_m1;
  logic [CW+IDX_W-1:0]  len_ext;

  assign idle_inc = (idle != IDLE_MAX) ? idle + 1'b1 : idle;
  assign idx_ext  = {{AW{1'b0}}, read_index};
  assign count_m1 = (count != '0) ? count - 1'b1 : '0;
  assign len_ext  = {{IDX_W{1'b0}}, count_m1};

  always_comb begin
    in_frame_next = in_frame;
    pending_next  = pending;
    count_next    = count;
    run_xor_next  = run_xor;
    idle_next     = idle;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = rx_byte;
    res           = '0;
    if (accept) begin
      unique case (req_t'(req_type))
        REQ_BYTE: begin
          if (!in_frame) begin
            in_frame_next = 1'b1;
            mem_we        = 1'b1;
            count_next    = CW'(1);
            run_xor_next  = rx_byte;
            idle_next     = '0;
          end else if (count != '0 && count < CW'(BUFFER_BYTES)) begin
            mem_we       = 1'b1;
            mem_addr     = count[AW-1:0];
            count_next   = count + 1'b1;
            run_xor_next = run_xor ^ rx_byte;
            idle_next    = '0;
          end else begin
            // store full, drop the frame
            in_frame_next = 1'b0;
            count_next    = '0;
            res.overflow  = 1'b1;
          end
        end
        REQ_TICK: begin
          if (in_frame) begin
            idle_next = idle_inc;
            if (idle_inc >= timeout) begin
              in_frame_next = 1'b0;
              if (run_xor == '0) begin
                pending_next = 1'b1;
                res.accepted = 1'b1;
              end else begin
                res.rejected = 1'b1;
              end
            end
          end
        end
        REQ_READ: begin
          mem_re    = 1'b1;
          mem_addr  = idx_ext[AW-1:0];
          res.rd_ok = idx_ext < (AW+IDX_W)'(BUFFER_BYTES);
        end
        REQ_CLAIM: begin
          if (pending) begin
            res.length   = len_ext[IDX_W-1:0];
            pending_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
    // a claim reports the flag as it was before clearing
    res.ready = (accept && req_t'(req_type) == REQ_CLAIM) ? pending : pending_next;
    res.busy  = in_frame_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout  <= TIMEOUT_RESET;
      in_frame <= 1'b0;
      pending  <= 1'b0;
      count    <= '0;
      run_xor  <= '0;
      idle     <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      in_frame <= in_frame_next;
      pending  <= pending_next;
      count    <= count_next;
      run_xor  <= run_xor_next;
      idle     <= idle_next;
    end
  end

endmodule

// ----- rtl/idle_timeout_xor_frame_receiver_top.sv -----
// two register stages, the read stage and the output register; out_valid rises once an accepted item has passed both
// throughput: one item per cycle while out_stall is low; the single store port serves at most one byte write
// or one byte read per item, and the output register plus a read stage keep flowing
// stall on the output backs up into in_stall after the read stage fills
// reset clears frame state, counters, flags and timeout (to 1); store is not cleared
`include "idle_timeout_xor_frame_receiver_top_defines.svh"

module idle_timeout_xor_frame_receiver_top import itxfr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic [IDX_W-1:0]     read_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 frame_accepted,
  output logic                 frame_rejected,
  output logic                 overflow_abort,
  output logic                 frame_ready,
  output logic [IDX_W-1:0]     frame_length,
  output logic [BYTE_W-1:0]    read_byte,
  output logic                 busy_receiving
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic              accept;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  itxfr_res_t        res, s1_res;
  logic              s1_valid, s1_move;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  itxfr_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .req_type    (req_type),
    .rx_byte     (rx_byte),
    .read_index  (read_index),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .res         (res)
  );

  itxfr_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_BYTES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // read stage: ram data lands here, held while stalled since no new read issues
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      frame_accepted <= s1_res.accepted;
      frame_rejected <= s1_res.rejected;
      overflow_abort <= s1_res.overflow;
      frame_ready    <= s1_res.ready;
      frame_length   <= s1_res.length;
      read_byte      <= s1_res.rd_ok ? mem_rdata : '0;
      busy_receiving <= s1_res.busy;
    end
  end

  `ITXFR_ASSERT_NOW(a_store_one_access, mem_we || mem_re, !(mem_we && mem_re))
  `ITXFR_ASSERT_NOW(a_good_end, out_valid && frame_accepted, frame_ready && !busy_receiving)
  `ITXFR_ASSERT_NOW(a_abort_idle, out_valid && overflow_abort, !busy_receiving && !frame_accepted && !frame_rejected)
  `ITXFR_ASSERT_NEXT(a_read_stage_holds, s1_valid && !s1_move, s1_valid && $stable(s1_res))

endmodule
